FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks run on posedge clk and are off while rst_n is low.
`ifndef SYNTHESIS
`define KT_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define KT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define KT_ASSERT(lbl, cond)
`define KT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hdl/kt_pkg.sv
`default_nettype none

package kt_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int FILL_W  = IDX_W + 1;
  localparam int CFG_W   = 5;
  localparam int SLOT_W  = 4;
  localparam int KEY_W   = 32;
  localparam int PAY_W   = 32;

  localparam logic [CFG_W-1:0] CAP_RST = 5'd16;

  localparam logic [1:0] K_FIND   = 2'd0;
  localparam logic [1:0] K_INSERT = 2'd1;
  localparam logic [1:0] K_DELETE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DUP      = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_MISSING  = 2'd3;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [PAY_W-1:0]        pay_t;
  typedef logic [IDX_W-1:0]        idx_t;

  typedef struct packed {
    logic [1:0] kind;
    key_t       key;
    pay_t       payload_in;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot_index;
    pay_t              payload_out;
  } out_t;

  typedef struct packed {
    logic re;
    idx_t raddr;
    logic we;
    idx_t waddr;
    key_t wkey;
    pay_t wpay;
  } store_req_t;

  typedef struct packed {
    key_t key;
    pay_t pay;
  } store_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/kt_store.sv
`default_nettype none

module kt_store (
  input  wire logic               clk,
  input  wire kt_pkg::store_req_t req,
  output kt_pkg::store_rsp_t      rsp
);
  import kt_pkg::*;

  key_t key_mem [ENTRIES];
  pay_t pay_mem [ENTRIES];
  store_rsp_t rsp_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      key_mem[req.waddr] <= req.wkey;
      pay_mem[req.waddr] <= req.wpay;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rsp_r.key <= key_mem[req.raddr];
      rsp_r.pay <= pay_mem[req.raddr];
    end
  end

  assign rsp = rsp_r;

endmodule

`default_nettype wire

FILE: hdl/kt_seq.sv
`default_nettype none

module kt_seq (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire kt_pkg::in_t              in_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output kt_pkg::out_t                  out_data,
  input  wire logic                     cfg_we,
  input  wire logic [kt_pkg::CFG_W-1:0] cfg_wdata,
  output kt_pkg::store_req_t            req,
  input  wire kt_pkg::store_rsp_t       rsp
);
  import kt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_COMP  = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]         state_r, state_nxt;
  in_t                item_r, item_nxt;
  logic [FILL_W-1:0]  cnt_r, cnt_nxt;
  logic               pend_r, pend_nxt;
  idx_t               pidx_r, pidx_nxt;
  logic [FILL_W-1:0]  rd_r, rd_nxt;
  logic [FILL_W-1:0]  wr_r, wr_nxt;
  logic               mv_r, mv_nxt;
  idx_t               mvdst_r, mvdst_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [CFG_W-1:0]   cap_r, cap_nxt;
  out_t               res_r, res_nxt;
  out_t               out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [FILL_W-1:0] cap;
  logic              hit;
  idx_t              fill_idx;
  idx_t              rd_idx;
  idx_t              wr_idx;

  always_comb begin
    if (32'(cap_r) > ENTRIES) begin
      cap = FILL_W'(ENTRIES);
    end else begin
      cap = FILL_W'(cap_r);
    end
  end

  assign hit      = pend_r && valid_r[pidx_r] && (rsp.key == item_r.key);
  assign fill_idx = fill_r[IDX_W-1:0];
  assign rd_idx   = rd_r[IDX_W-1:0];
  assign wr_idx   = wr_r[IDX_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    pidx_nxt      = pidx_r;
    rd_nxt        = rd_r;
    wr_nxt        = wr_r;
    mv_nxt        = mv_r;
    mvdst_nxt     = mvdst_r;
    fill_nxt      = fill_r;
    valid_nxt     = valid_r;
    cap_nxt       = cfg_we ? cfg_wdata : cap_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    req           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          cnt_nxt  = '0;
          pend_nxt = 1'b0;
          res_nxt  = '0;
          if (in_data.kind == K_FIND || in_data.kind == K_INSERT ||
              in_data.kind == K_DELETE) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          state_nxt = S_FIN;
          unique case (item_r.kind)
            K_FIND: begin
              res_nxt.slot_index  = SLOT_W'(pidx_r);
              res_nxt.payload_out = rsp.pay;
            end
            K_INSERT: res_nxt.status = ST_DUP;
            default:  valid_nxt[pidx_r] = 1'b0;
          endcase
        end else if (cnt_r < fill_r) begin
          req.re    = 1'b1;
          req.raddr = cnt_r[IDX_W-1:0];
          pend_nxt  = 1'b1;
          pidx_nxt  = cnt_r[IDX_W-1:0];
          cnt_nxt   = cnt_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (item_r.kind != K_INSERT) begin
            res_nxt.status = ST_MISSING;
            state_nxt      = S_FIN;
          end else if (fill_r >= cap) begin
            rd_nxt    = '0;
            wr_nxt    = '0;
            mv_nxt    = 1'b0;
            state_nxt = S_COMP;
          end else begin
            req.we              = 1'b1;
            req.waddr           = fill_idx;
            req.wkey            = item_r.key;
            req.wpay            = item_r.payload_in;
            valid_nxt[fill_idx] = 1'b1;
            fill_nxt            = fill_r + 1'b1;
            res_nxt.slot_index  = SLOT_W'(fill_idx);
            state_nxt           = S_FIN;
          end
        end
      end

      S_COMP: begin
        // a move read last cycle lands at its destination now
        if (mv_r) begin
          req.we    = 1'b1;
          req.waddr = mvdst_r;
          req.wkey  = rsp.key;
          req.wpay  = rsp.pay;
        end
        mv_nxt = 1'b0;
        if (rd_r < fill_r) begin
          if (valid_r[rd_idx]) begin
            if (wr_r != rd_r) begin
              req.re            = 1'b1;
              req.raddr         = rd_idx;
              valid_nxt[wr_idx] = 1'b1;
              valid_nxt[rd_idx] = 1'b0;
              mv_nxt            = 1'b1;
              mvdst_nxt         = wr_idx;
            end
            wr_nxt = wr_r + 1'b1;
          end
          rd_nxt = rd_r + 1'b1;
        end else begin
          fill_nxt  = wr_r;
          state_nxt = S_PLACE;
        end
      end

      S_PLACE: begin
        state_nxt = S_FIN;
        if (fill_r >= cap) begin
          res_nxt.status = ST_OVERFLOW;
        end else begin
          req.we              = 1'b1;
          req.waddr           = fill_idx;
          req.wkey            = item_r.key;
          req.wpay            = item_r.payload_in;
          valid_nxt[fill_idx] = 1'b1;
          fill_nxt            = fill_r + 1'b1;
          res_nxt.slot_index  = SLOT_W'(fill_idx);
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      mv_r        <= 1'b0;
      fill_r      <= '0;
      valid_r     <= '0;
      cap_r       <= CAP_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      mv_r        <= mv_nxt;
      fill_r      <= fill_nxt;
      valid_r     <= valid_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    cnt_r   <= cnt_nxt;
    pidx_r  <= pidx_nxt;
    rd_r    <= rd_nxt;
    wr_r    <= wr_nxt;
    mvdst_r <= mvdst_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

FILE: hdl/keyed_table_with_compaction_unit.sv
// Operation: find/delete scan the filled slots and stop early on a hit; insert scans them
// too and compacts the table first when the fill count has reached the capacity.
// Flow: one transaction at a time, in_ready back in the cycle after the result is loaded.
// Result register lets the next transaction be accepted while a result waits on out_ready.
// Reset (rst_n low, synchronous): valid marks and fill count cleared, capacity set to 16.
`default_nettype none

`include "assert_macros.svh"

module keyed_table_with_compaction_unit (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire kt_pkg::in_t              in_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output kt_pkg::out_t                  out_data,
  input  wire logic                     cfg_we,
  input  wire logic [kt_pkg::CFG_W-1:0] cfg_wdata
);
  import kt_pkg::*;

  store_req_t req;
  store_rsp_t rsp;

  kt_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp)
  );

  kt_store u_store (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  `KT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `KT_ASSERT(a_pay_only_on_find, !out_valid || out_data.status == ST_OK || out_data.payload_out == '0)
  `KT_ASSERT(a_slot_zero_on_error, !out_valid || out_data.status == ST_OK || out_data.slot_index == '0)
  `KT_ASSERT(a_no_read_write_same_cycle_clash, !(req.we && req.re && req.waddr == req.raddr))

endmodule

`default_nettype wire

FILE: tb/sv/table_checker.sv
`timescale 1ns / 1ps

module table_checker (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  kt_pkg::in_t              in_data,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  kt_pkg::out_t             out_data,
  input  logic                     cfg_we,
  input  logic [kt_pkg::CFG_W-1:0] cfg_wdata,
  output int                       outstanding,
  output int                       errors
);
  import kt_pkg::*;

  logic             live [ENTRIES];
  key_t             keys [ENTRIES];
  pay_t             pays [ENTRIES];
  int               fill;
  logic [CFG_W-1:0] capacity;
  out_t             expected_results [$];

  initial begin
    outstanding = 0;
    errors      = 0;
  end

  function automatic int find_slot(key_t k);
    for (int i = 0; i < fill; i++) begin
      if (live[i] && keys[i] === k) return i;
    end
    return ENTRIES;
  endfunction

  // stable compaction: surviving entries slide down over deleted ones
  function automatic void squeeze();
    int wr = 0;
    for (int rd = 0; rd < fill; rd++) begin
      if (live[rd]) begin
        if (wr != rd) begin
          keys[wr] = keys[rd];
          pays[wr] = pays[rd];
          live[wr] = 1'b1;
          live[rd] = 1'b0;
        end
        wr++;
      end
    end
    fill = wr;
  endfunction

  function automatic out_t apply_op(in_t t);
    out_t r;
    int   hit;
    int   lim;
    r   = '0;
    lim = (capacity > ENTRIES) ? ENTRIES : int'(capacity);
    case (t.kind)
      K_FIND: begin
        hit = find_slot(t.key);
        if (hit < ENTRIES) begin
          r.slot_index  = SLOT_W'(hit);
          r.payload_out = pays[hit];
        end else begin
          r.status = ST_MISSING;
        end
      end
      K_INSERT: begin
        if (find_slot(t.key) < ENTRIES) begin
          r.status = ST_DUP;
        end else begin
          if (fill >= lim) squeeze();
          if (fill >= lim || fill >= ENTRIES) begin
            r.status = ST_OVERFLOW;
          end else begin
            r.slot_index = SLOT_W'(fill);
            live[fill]   = 1'b1;
            keys[fill]   = t.key;
            pays[fill]   = t.payload_in;
            fill++;
          end
        end
      end
      K_DELETE: begin
        hit = find_slot(t.key);
        if (hit < ENTRIES) begin
          live[hit] = 1'b0;
        end else begin
          r.status = ST_MISSING;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      if (errors < 10) $display("mismatch %s: expected %0h got %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) live[i] = 1'b0;
      fill     = 0;
      capacity = CAP_RST;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (errors < 10) $display("unexpected transaction on output: %0h", out_data);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(want.status), 32'(out_data.status));
          check_field("slot_index", 32'(want.slot_index), 32'(out_data.slot_index));
          check_field("payload_out", want.payload_out, out_data.payload_out);
        end
      end
      if (in_valid && in_ready) expected_results.push_back(apply_op(in_data));
      if (cfg_we) capacity = cfg_wdata;
    end
    outstanding <= expected_results.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import kt_pkg::*;

  localparam logic [1:0] K_NOOP = 2'd3;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_t              in_data;
  logic             out_valid;
  logic             out_ready;
  out_t             out_data;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  logic             steady;
  int               outstanding;
  int               errors;
  key_t             key_pool [24];

  always #5 clk = ~clk;

  keyed_table_with_compaction_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  table_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .outstanding (outstanding),
    .errors      (errors)
  );

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 27);
  end

  task automatic send_op(input in_t t);
    while (!steady && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic op(input logic [1:0] kind, input key_t k, input pay_t p);
    in_t t;
    t.kind       = kind;
    t.key        = k;
    t.payload_in = p;
    send_op(t);
  endtask

  // hold off the sender until every outstanding transaction has completed
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic in_t rand_op(int pool_n);
    in_t t;
    int  r;
    r = $urandom_range(99);
    t.kind = (r < 40) ? K_INSERT : (r < 70) ? K_FIND : (r < 95) ? K_DELETE : K_NOOP;
    t.key  = ($urandom_range(99) < 85) ? key_pool[$urandom_range(pool_n - 1)]
                                       : key_t'($urandom());
    t.payload_in = $urandom();
    return t;
  endfunction

  initial begin
    logic [CFG_W-1:0] caps [10];
    key_t             corner [4];
    int               pool_n;
    caps   = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd8, 5'd15, 5'd4, 5'd12};
    corner = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sd1};
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    steady    = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extremes, duplicates, deletes
    op(K_FIND,   32'sh1234_5678, 32'h0);
    op(K_DELETE, 32'sh1234_5678, 32'h0);
    op(K_NOOP,   -32'sd1,        32'hFFFF_FFFF);
    op(K_INSERT, 32'sh8000_0000, 32'h0000_0000);
    op(K_INSERT, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
    op(K_INSERT, -32'sd1,        32'hA5A5_A5A5);
    op(K_INSERT, 32'sh0,         32'h5A5A_5A5A);
    op(K_INSERT, -32'sd1,        32'h1111_1111);
    op(K_FIND,   32'sh7FFF_FFFF, 32'h0);
    op(K_FIND,   -32'sd1,        32'h0);
    op(K_FIND,   32'sh8000_0000, 32'h0);
    op(K_DELETE, -32'sd1,        32'h0);
    op(K_FIND,   -32'sd1,        32'h0);
    op(K_DELETE, -32'sd1,        32'h0);
    // capacity below the fill pointer: compaction then overflow
    settle();
    set_capacity(5'd3);
    op(K_INSERT, 32'sd77,        32'hDEAD_BEEF);
    op(K_FIND,   32'sh0,         32'h0);
    op(K_DELETE, 32'sh0,         32'h0);
    op(K_INSERT, 32'sd5,         32'h0000_0005);
    op(K_INSERT, 32'sd6,         32'h0000_0006);
    settle();
    set_capacity(5'd0);
    op(K_INSERT, 32'sd9,         32'h0000_0009);
    op(K_INSERT, 32'sd5,         32'h0000_0000);
    settle();
    set_capacity(5'd31);
    op(K_INSERT, 32'sd9,         32'hFFFF_0000);
    op(K_FIND,   32'sd9,         32'h0);

    for (int p = 0; p < 10; p++) begin
      settle();
      set_capacity(p == 9 ? CFG_W'($urandom_range(31)) : caps[p]);
      steady <= (p == 4);
      pool_n = $urandom_range(2, 24);
      for (int i = 0; i < 24; i++) key_pool[i] = key_t'($urandom());
      key_pool[$urandom_range(pool_n - 1)] = corner[p % 4];
      repeat (195) send_op(rand_op(pool_n));
    end

    settle();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/kt_pkg.sv
hdl/kt_store.sv
hdl/kt_seq.sv
hdl/keyed_table_with_compaction_unit.sv
tb/sv/table_checker.sv
tb/sv/tb_top.sv
